FILE: src/hash_chain_anchor_sealer_core_macros.svh
// Assertion macros for the hash chain anchor sealer.
// Included by the top level; no other dependencies.
`ifndef HASH_CHAIN_ANCHOR_SEALER_CORE_MACROS_SVH
`define HASH_CHAIN_ANCHOR_SEALER_CORE_MACROS_SVH

// same-cycle implication
`define HCAS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HCAS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/hcas_pkg.sv
// Shared constants, types and helpers for the hash chain anchor sealer.
// No dependencies.
package hcas_pkg;

	localparam logic [63:0] FNV_BASIS  = 64'hcbf29ce484222325;
	localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;   // prime = 2^40 + 0x1b3
	localparam int unsigned FNV_PRIME_SHIFT = 40;
	localparam logic [63:0] GOLDEN_ADD = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;

	localparam logic [1:0] STG_INPUT   = 2'd0;
	localparam logic [1:0] STG_OUTPUT  = 2'd1;
	localparam logic [1:0] STG_CONTEXT = 2'd2;
	localparam logic [1:0] STG_UNUSED  = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} mul_sts_t;

	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		begin
			x = h ^ {56'd0, b};
			fnv_step = (x << FNV_PRIME_SHIFT) + x * {55'd0, FNV_PRIME_LO};
		end
	endfunction

endpackage

FILE: src/hcas_mul64.sv
// Iterative 64x64 multiplier keeping the low 64 bits, one 32x32 product per cycle.
// Depends on hcas_pkg.
module hcas_mul64 import hcas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output mul_sts_t    sts,
	output logic [63:0] prod
);

	logic [63:0] a_q, b_q, acc_q;
	logic [1:0]  step_q;
	logic        busy_q, done_q;
	logic [31:0] a_sel, b_sel;
	logic [63:0] pr;

	// step 0: lo*lo, step 1: alo*bhi, step 2: ahi*blo
	always_comb begin
		a_sel = (step_q == 2'd2) ? a_q[63:32] : a_q[31:0];
		b_sel = (step_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	end

	assign pr = 64'(a_sel) * 64'(b_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					step_q <= 2'd0;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end
		if (busy_q) begin
			if (step_q == 2'd0)
				acc_q <= pr;
			else
				acc_q <= acc_q + {pr[31:0], 32'd0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign prod     = acc_q;

endmodule

FILE: src/hash_chain_anchor_sealer_core.sv
// Top level of the hash chain anchor sealer: FNV-1a 64 per vector, chained anchor fold.
// Depends on hcas_pkg, hcas_mul64 and hash_chain_anchor_sealer_core_macros.svh.
//
// Usage: bytes arrive on the in channel (data_byte, byte_present, vector_end),
// three vectors per record: input, output, context. byte_present 0 with
// vector_end 1 closes a vector without adding a byte. One transaction per
// record leaves on the out channel when the context vector closes: new anchor
// plus the three hashes. An item that does not close a vector leaves the
// input ready. An item that closes a vector holds off input while the fold
// runs through steps PRE, MA, XA, MB and FIN: two 64-bit multiplies through
// one shared 32x32 multiplier, three products and a done strobe each.
// Output is a register: the next record's bytes are taken while a result waits.
// A stalled receiver only holds the block when the next record would close;
// it then waits in the final step until the pending result is taken.
// Reset: chained anchor 0, running hash at the offset basis, first vector open.
`include "hash_chain_anchor_sealer_core_macros.svh"
module hash_chain_anchor_sealer_core import hcas_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        vector_end,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] anchor,
	output logic [63:0] input_hash,
	output logic [63:0] output_hash,
	output logic [63:0] context_hash
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PRE  = 6'b000010,
		ST_MA   = 6'b000100,
		ST_XA   = 6'b001000,
		ST_MB   = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t      state_q;
	logic [63:0] run_q, h_q, chain_q, partial_q, first_q, second_q;
	logic [1:0]  stage_q;
	logic        out_valid_q;
	logic [63:0] anchor_q, in_h_q, out_h_q, ctx_h_q;

	logic        in_fire, out_hold, fin_go, seal_go;
	logic [63:0] run_nxt, base, z_sum, z_pre, x_a, fold_res;
	logic        mul_start;
	logic [63:0] mul_a, mul_b, mul_p;
	mul_sts_t    mul_sts;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_hold = out_valid_q && !out_ready;
	assign run_nxt  = byte_present ? fnv_step(run_q, data_byte) : run_q;

	always_comb begin
		base  = (stage_q == STG_OUTPUT || stage_q == STG_CONTEXT) ? partial_q : chain_q;
		z_sum = base + GOLDEN_ADD + (h_q << 6) + (h_q >> 2);
		z_pre = z_sum ^ (z_sum >> 30);
	end

	assign x_a      = mul_p ^ (mul_p >> 27);
	assign fold_res = mul_p ^ (mul_p >> 31);

	assign mul_start = (state_q == ST_PRE) || (state_q == ST_XA);
	assign mul_a     = (state_q == ST_PRE) ? z_pre : x_a;
	assign mul_b     = (state_q == ST_PRE) ? MIX_MUL_A : MIX_MUL_B;
	assign fin_go    = !(stage_q == STG_CONTEXT && out_hold);
	assign seal_go   = (state_q == ST_FIN) && fin_go && (stage_q == STG_CONTEXT);

	hcas_mul64 u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.sts    (mul_sts),
		.prod   (mul_p)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			run_q       <= FNV_BASIS;
			chain_q     <= 64'd0;
			partial_q   <= 64'd0;
			stage_q     <= STG_INPUT;
			first_q     <= 64'd0;
			second_q    <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (seal_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (vector_end) begin
							run_q   <= FNV_BASIS;
							state_q <= ST_PRE;
						end else begin
							run_q <= run_nxt;
						end
					end
				end
				ST_PRE: state_q <= ST_MA;
				ST_MA:  if (mul_sts.done) state_q <= ST_XA;
				ST_XA:  state_q <= ST_MB;
				ST_MB:  if (mul_sts.done) state_q <= ST_FIN;
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						unique case (stage_q)
							STG_OUTPUT: begin
								partial_q <= fold_res;
								second_q  <= h_q;
								stage_q   <= STG_CONTEXT;
							end
							STG_CONTEXT: begin
								chain_q   <= fold_res;
								partial_q <= fold_res;
								stage_q   <= STG_INPUT;
							end
							default: begin
								partial_q <= fold_res;
								first_q   <= h_q;
								stage_q   <= STG_OUTPUT;
							end
						endcase
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && vector_end)
			h_q <= run_nxt;
		if (seal_go) begin
			anchor_q <= fold_res;
			in_h_q   <= first_q;
			out_h_q  <= second_q;
			ctx_h_q  <= h_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign anchor       = anchor_q;
	assign input_hash   = in_h_q;
	assign output_hash  = out_h_q;
	assign context_hash = ctx_h_q;

	`HCAS_ASSERT_IMP(a_ready_mul_idle, clk, arst_n, in_ready, !mul_sts.busy && !mul_sts.done, "input ready while multiplier active")
	`HCAS_ASSERT_IMP(a_done_in_wait, clk, arst_n, mul_sts.done, state_q == ST_MA || state_q == ST_MB, "multiplier done outside a wait step")
	`HCAS_ASSERT_IMP(a_stage_legal, clk, arst_n, 1'b1, stage_q != STG_UNUSED, "unused vector stage code")
	`HCAS_ASSERT_NXT(a_result_loads, clk, arst_n, seal_go, out_valid && anchor == chain_q, "sealed record not presented")

endmodule

FILE: bench/testbench.sv
// Testbench for hash_chain_anchor_sealer_core: directed records, then random records.
// Expected seals come from an in-bench FNV-1a/chain-fold predictor; needs hcas_pkg.
// Both channels idle at random; every output transaction is checked field by field.
module testbench;
	import hcas_pkg::*;

	localparam logic [63:0] FNV_MULT = 64'h100000001b3;
	localparam logic [63:0] NO_HASH = 64'd0;
	localparam int unsigned PLAN_LEN = 20;
	localparam int unsigned RANDOM_ITEMS = 1500;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_GAP = 14;

	typedef struct packed {
		logic [63:0] anchor_v;
		logic [63:0] in_h;
		logic [63:0] out_h;
		logic [63:0] ctx_h;
	} seal_t;

	typedef struct packed {
		logic [7:0]  b;
		logic        p;
		logic        e;
		logic        typed;
		logic [63:0] in_h;
		logic [63:0] out_h;
		logic [63:0] ctx_h;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        byte_present = 1'b0;
	logic        vector_end = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] anchor;
	logic [63:0] input_hash;
	logic [63:0] output_hash;
	logic [63:0] context_hash;

	// predictor state, at reset values
	logic [63:0] cur_vec_hash = FNV_BASIS;
	logic [63:0] sealed_anchor = 64'd0;
	logic [63:0] open_anchor = 64'd0;
	logic [1:0]  open_stage = STG_INPUT;
	logic [63:0] held_in_hash = 64'd0;
	logic [63:0] held_out_hash = 64'd0;

	seal_t       seal_q[$];
	seal_t       got_seal;
	plan_row_t   plan [PLAN_LEN];
	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned items_sent = 0;
	bit          quiet = 1'b0;
	bit          in_fire = 1'b0;
	bit          out_fire = 1'b0;

	always #1 clk = ~clk;

	hash_chain_anchor_sealer_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.vector_end   (vector_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.anchor       (anchor),
		.input_hash   (input_hash),
		.output_hash  (output_hash),
		.context_hash (context_hash)
	);

	function automatic logic [63:0] chain_fold(input logic [63:0] acc, input logic [63:0] h);
		logic [63:0] z;
		z = acc + GOLDEN_ADD + (h << 6) + (h >> 2);
		z = z ^ (z >> 30);
		z = z * MIX_MUL_A;
		z = z ^ (z >> 27);
		z = z * MIX_MUL_B;
		z = z ^ (z >> 31);
		return z;
	endfunction

	function automatic int unsigned draw_gap();
		return quiet ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic seal_predict(input logic [7:0] b, input logic p, input logic e);
		logic [63:0] h;
		seal_t s;
		if (p)
			cur_vec_hash = (cur_vec_hash ^ {56'd0, b}) * FNV_MULT;
		if (e) begin
			h = cur_vec_hash;
			cur_vec_hash = FNV_BASIS;
			case (open_stage)
			STG_OUTPUT: begin
				open_anchor = chain_fold(open_anchor, h);
				held_out_hash = h;
				open_stage = STG_CONTEXT;
			end
			STG_CONTEXT: begin
				s.anchor_v = chain_fold(open_anchor, h);
				s.in_h = held_in_hash;
				s.out_h = held_out_hash;
				s.ctx_h = h;
				sealed_anchor = s.anchor_v;
				open_anchor = s.anchor_v;
				open_stage = STG_INPUT;
				seal_q.push_back(s);
			end
			default: begin
				// input vector; the unused stage code lands here too
				open_anchor = chain_fold(sealed_anchor, h);
				held_in_hash = h;
				open_stage = STG_OUTPUT;
			end
			endcase
		end
	endtask

	// returns at the edge where the transaction is taken
	task automatic send_item(input logic [7:0] b, input logic p, input logic e);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_present <= p;
		vector_end <= e;
		do @(posedge clk); while (!in_fire);
		seal_predict(b, p, e);
		if (p || e)
			items_sent++;
	endtask

	task automatic send_vector(input int unsigned len);
		bit on_byte;
		on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
		for (int unsigned k = 0; k < len; k++) begin
			if ($urandom_range(0, 11) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, on_byte && (k == len - 1));
		end
		if (!on_byte)
			send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic void check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endfunction

	// sample between edges: the values here hold through the next rising edge
	always @(negedge clk) begin
		in_fire = arst_n && in_valid && in_ready;
		out_fire = arst_n && out_valid && out_ready;
		if (out_fire) begin
			if (seal_q.size() == 0) begin
				$display("%0t: unexpected transaction: expected none, actual anchor %h",
					$time, anchor);
				errors++;
			end else begin
				got_seal = seal_q.pop_front();
				check_field("anchor", got_seal.anchor_v, anchor);
				check_field("input_hash", got_seal.in_h, input_hash);
				check_field("output_hash", got_seal.out_h, output_hash);
				check_field("context_hash", got_seal.ctx_h, context_hash);
			end
		end
	end

	initial begin
		int unsigned stall;
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_fire);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d transactions outstanding", $time, seal_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		seal_t s;
		bit pressed;
		pressed = 1'b0;
		plan = '{
			'{8'h00, 1'b0, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h00, 1'b0, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h00, 1'b0, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h00, 1'b0, 1'b1, 1'b1, FNV_BASIS, FNV_BASIS, FNV_BASIS},
			'{8'h00, 1'b1, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'hff, 1'b1, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'hff, 1'b0, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h80, 1'b1, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h7f, 1'b1, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'hff, 1'b1, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'hff, 1'b1, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'hab, 1'b0, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h55, 1'b1, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'haa, 1'b1, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h00, 1'b0, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h01, 1'b1, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'hfe, 1'b1, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'hfe, 1'b0, 1'b0, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h01, 1'b1, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH},
			'{8'h5a, 1'b0, 1'b1, 1'b0, NO_HASH, NO_HASH, NO_HASH}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int unsigned i = 0; i < PLAN_LEN; i++) begin
			send_item(plan[i].b, plan[i].p, plan[i].e);
			if (plan[i].typed) begin
				// record of three empty vectors: hashes are the basis by definition
				s = seal_q.pop_back();
				s.in_h = plan[i].in_h;
				s.out_h = plan[i].out_h;
				s.ctx_h = plan[i].ctx_h;
				seal_q.push_back(s);
			end
		end

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 7) == 0)
				quiet = ~quiet;
			for (int v = 0; v < 3; v++)
				send_vector(($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
					: $urandom_range(0, 5));
			if (!pressed && items_sent >= RANDOM_ITEMS / 2) begin
				pressed = 1'b1;
				in_valid <= 1'b0;
				while (seal_q.size() != 0) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (seal_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
